[sv/zlib_stored_framer_adler32_unit_defines.svh]
// ============================================================================
// zlib stored framer - assertion macros
// Shared concurrent assertion helpers for the framer RTL.
// ============================================================================
`ifndef ZLIB_STORED_FRAMER_ADLER32_UNIT_DEFINES_SVH
`define ZLIB_STORED_FRAMER_ADLER32_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ZSFA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define ZSFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/zsfa_pkg.sv]
// ============================================================================
// zsfa_pkg
// Constants, types and helpers shared by the zlib stored framer modules.
// ============================================================================
`default_nettype none

package zsfa_pkg;

    localparam int DIM_W     = 15;
    localparam int ROW_W     = 17;
    localparam int RAW_W     = 31;
    localparam int BLK_W     = 16;
    localparam int SUM_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [7:0]       ZLIB_CMF   = 8'h78;
    localparam logic [7:0]       ZLIB_FLG   = 8'h01;
    localparam logic [7:0]       FILTER_NONE = 8'h00;
    localparam logic [BLK_W-1:0] BLOCK_MAX  = 16'd65535;
    localparam logic [SUM_W-1:0] ADLER_MOD  = 16'd65521;
    localparam logic [DIM_W-1:0] MAX_DIM    = 15'd16384;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    typedef enum logic [12:0] {
        ST_IDLE = 13'b0000000000001,
        ST_ZH0  = 13'b0000000000010,
        ST_ZH1  = 13'b0000000000100,
        ST_BH0  = 13'b0000000001000,
        ST_BH1  = 13'b0000000010000,
        ST_BH2  = 13'b0000000100000,
        ST_BH3  = 13'b0000001000000,
        ST_BH4  = 13'b0000010000000,
        ST_RAW  = 13'b0000100000000,
        ST_TR0  = 13'b0001000000000,
        ST_TR1  = 13'b0010000000000,
        ST_TR2  = 13'b0100000000000,
        ST_TR3  = 13'b1000000000000
    } seq_state_t;

    // one stream byte handed to the output register
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } emit_t;

    // checksum control
    typedef struct packed {
        logic       upd;
        logic       clr;
        logic [7:0] data;
    } adler_ctl_t;

    typedef struct packed {
        logic [SUM_W-1:0] high;
        logic [SUM_W-1:0] low;
    } adler_sums_t;

    // zero reads as 1, anything above the maximum is clamped
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) r = {{(DIM_W-1){1'b0}}, 1'b1};
        else if (v > MAX_DIM) r = MAX_DIM;
        else r = v;
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/zsfa_adler.sv]
// ============================================================================
// zsfa_adler
// Running Adler-32 sums, one raw byte per cycle while upd is set.
// ============================================================================
`default_nettype none

`include "zlib_stored_framer_adler32_unit_defines.svh"

module zsfa_adler (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire zsfa_pkg::adler_ctl_t ctl_i,
    output zsfa_pkg::adler_sums_t    sums_o
);
    import zsfa_pkg::*;

    logic [SUM_W-1:0] low_reg, low_next;
    logic [SUM_W-1:0] high_reg, high_next;
    logic [SUM_W:0]   low_sum, high_sum;

    always_comb begin
        low_sum   = {1'b0, low_reg} + {{(SUM_W-7){1'b0}}, ctl_i.data};
        low_next  = (low_sum >= {1'b0, ADLER_MOD}) ? SUM_W'(low_sum - {1'b0, ADLER_MOD})
                                                   : low_sum[SUM_W-1:0];
        high_sum  = {1'b0, high_reg} + {1'b0, low_next};
        high_next = (high_sum >= {1'b0, ADLER_MOD}) ? SUM_W'(high_sum - {1'b0, ADLER_MOD})
                                                    : high_sum[SUM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg  <= SUM_W'(1);
            high_reg <= '0;
        end else if (ctl_i.clr) begin
            low_reg  <= SUM_W'(1);
            high_reg <= '0;
        end else if (ctl_i.upd) begin
            low_reg  <= low_next;
            high_reg <= high_next;
        end
    end

    assign sums_o.low  = low_reg;
    assign sums_o.high = high_reg;

    `ZSFA_ASSERT_NOW(a_sums_reduced, aclk, aresetn, 1'b1,
        (low_reg < ADLER_MOD) && (high_reg < ADLER_MOD), "adler sum not reduced")

endmodule

`default_nettype wire

[sv/zsfa_out_reg.sv]
// ============================================================================
// zsfa_out_reg
// Output register between the sequencer and the master stream port.
// ============================================================================
`default_nettype none

`include "zlib_stored_framer_adler32_unit_defines.svh"

module zsfa_out_reg (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire zsfa_pkg::emit_t emit_i,
    output logic             slot_free_o,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast
);
    import zsfa_pkg::*;

    logic       valid_reg;
    logic [7:0] data_reg;
    logic       last_reg;

    assign slot_free_o = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (slot_free_o) begin
            valid_reg <= emit_i.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_free_o && emit_i.valid) begin
            data_reg <= emit_i.data;
            last_reg <= emit_i.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

    `ZSFA_ASSERT_NOW(a_no_overwrite, aclk, aresetn, emit_i.valid, slot_free_o,
        "byte offered while output slot full")

endmodule

`default_nettype wire

[sv/zsfa_seq.sv]
// ============================================================================
// zsfa_seq
// Framing sequencer: zlib header, block headers, filter and pixel bytes, trailer.
// ============================================================================
`default_nettype none

`include "zlib_stored_framer_adler32_unit_defines.svh"

module zsfa_seq (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [zsfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [zsfa_pkg::DIM_W-1:0]    cfg_data,
    input  wire logic                          slot_free_i,
    input  wire zsfa_pkg::adler_sums_t         sums_i,
    output zsfa_pkg::emit_t                    emit_o,
    output zsfa_pkg::adler_ctl_t               adl_ctl_o
);
    import zsfa_pkg::*;

    seq_state_t       state_reg, state_next;
    logic [DIM_W-1:0] width_reg, height_reg;
    logic [RAW_W-1:0] raw_left_reg, raw_left_next;
    logic [BLK_W-1:0] blk_left_reg, blk_left_next;
    logic [ROW_W-1:0] row_cnt_reg, row_cnt_next;
    logic             started_reg, started_next;
    logic             filter_reg, filter_next;
    logic [7:0]       cur_byte_reg, cur_byte_next;

    logic             adv, done, take;
    logic [ROW_W-1:0] row_len, row_inc;
    logic [RAW_W-1:0] raw_total;
    logic [BLK_W-1:0] blk_len, blk_nlen;
    logic [7:0]       raw_byte;

    // dimensions only change between images, never next to a pixel transfer
    assign cfg_ready = (state_reg == ST_IDLE) && !started_reg && !s_tvalid;

    assign row_len   = {eff_dim(width_reg), 2'b00};
    assign raw_total = RAW_W'({1'b0, row_len} + 18'd1) * RAW_W'(eff_dim(height_reg));
    assign blk_len   = (raw_left_reg > RAW_W'(BLOCK_MAX)) ? BLOCK_MAX
                                                         : raw_left_reg[BLK_W-1:0];
    assign blk_nlen  = ~blk_len;
    assign raw_byte  = filter_reg ? FILTER_NONE : cur_byte_reg;
    assign row_inc   = row_cnt_reg + ROW_W'(1);

    assign adv  = (state_reg != ST_IDLE) && slot_free_i;
    assign take = (state_reg == ST_IDLE) || (adv && done);
    assign s_tready = take;

    always_comb begin
        state_next    = state_reg;
        raw_left_next = raw_left_reg;
        blk_left_next = blk_left_reg;
        row_cnt_next  = row_cnt_reg;
        started_next  = started_reg;
        filter_next   = filter_reg;
        cur_byte_next = cur_byte_reg;
        emit_o        = '0;
        adl_ctl_o     = '0;
        adl_ctl_o.data = raw_byte;
        done          = 1'b0;

        if (adv) begin
            emit_o.valid = 1'b1;
            case (state_reg)
                ST_ZH0: begin
                    emit_o.data   = ZLIB_CMF;
                    raw_left_next = raw_total;
                    blk_left_next = '0;
                    row_cnt_next  = '0;
                    started_next  = 1'b1;
                    adl_ctl_o.clr = 1'b1;
                    state_next    = ST_ZH1;
                end
                ST_ZH1: begin
                    emit_o.data = ZLIB_FLG;
                    state_next  = (blk_left_reg == '0) ? ST_BH0 : ST_RAW;
                end
                ST_BH0: begin
                    emit_o.data = {7'd0, raw_left_reg <= RAW_W'(BLOCK_MAX)};
                    state_next  = ST_BH1;
                end
                ST_BH1: begin
                    emit_o.data = blk_len[7:0];
                    state_next  = ST_BH2;
                end
                ST_BH2: begin
                    emit_o.data = blk_len[15:8];
                    state_next  = ST_BH3;
                end
                ST_BH3: begin
                    emit_o.data = blk_nlen[7:0];
                    state_next  = ST_BH4;
                end
                ST_BH4: begin
                    emit_o.data   = blk_nlen[15:8];
                    blk_left_next = blk_len;
                    state_next    = ST_RAW;
                end
                ST_RAW: begin
                    emit_o.data   = raw_byte;
                    adl_ctl_o.upd = 1'b1;
                    blk_left_next = blk_left_reg - BLK_W'(1);
                    raw_left_next = raw_left_reg - RAW_W'(1);
                    if (filter_reg) begin
                        // filter byte done, pixel byte follows
                        filter_next = 1'b0;
                        state_next  = (blk_left_reg == BLK_W'(1)) ? ST_BH0 : ST_RAW;
                    end else begin
                        row_cnt_next = (row_inc >= row_len) ? '0 : row_inc;
                        if (raw_left_reg == RAW_W'(1)) begin
                            state_next = ST_TR0;
                        end else begin
                            done       = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                end
                ST_TR0: begin
                    emit_o.data = sums_i.high[15:8];
                    state_next  = ST_TR1;
                end
                ST_TR1: begin
                    emit_o.data = sums_i.high[7:0];
                    state_next  = ST_TR2;
                end
                ST_TR2: begin
                    emit_o.data = sums_i.low[15:8];
                    state_next  = ST_TR3;
                end
                ST_TR3: begin
                    emit_o.data   = sums_i.low[7:0];
                    emit_o.last   = 1'b1;
                    adl_ctl_o.clr = 1'b1;
                    blk_left_next = '0;
                    row_cnt_next  = '0;
                    started_next  = 1'b0;
                    done          = 1'b1;
                    state_next    = ST_IDLE;
                end
                default: begin
                    emit_o.valid = 1'b0;
                    state_next   = ST_IDLE;
                end
            endcase
        end

        // next pixel byte enters without a bubble
        if (take && s_tvalid) begin
            cur_byte_next = s_tdata;
            filter_next   = (row_cnt_next == '0);
            if (!started_next) state_next = ST_ZH0;
            else state_next = (blk_left_next == '0) ? ST_BH0 : ST_RAW;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            raw_left_reg <= '0;
            blk_left_reg <= '0;
            row_cnt_reg  <= '0;
            started_reg  <= 1'b0;
            filter_reg   <= 1'b0;
            width_reg    <= DIM_W'(1);
            height_reg   <= DIM_W'(1);
        end else begin
            state_reg    <= state_next;
            raw_left_reg <= raw_left_next;
            blk_left_reg <= blk_left_next;
            row_cnt_reg  <= row_cnt_next;
            started_reg  <= started_next;
            filter_reg   <= filter_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_byte_reg <= cur_byte_next;
    end

    `ZSFA_ASSERT_NOW(a_last_at_end, aclk, aresetn, emit_o.valid && emit_o.last,
        raw_left_reg == '0, "stream end flagged with raw bytes left")
    `ZSFA_ASSERT_NOW(a_blk_within_raw, aclk, aresetn, started_reg,
        RAW_W'(blk_left_reg) <= raw_left_reg, "block count exceeds raw count")
    `ZSFA_ASSERT_NEXT(a_hdr_then_flg, aclk, aresetn, adv && (state_reg == ST_ZH0),
        started_reg && (state_reg == ST_ZH1), "zlib header not followed by flag byte")

endmodule

`default_nettype wire

[sv/zlib_stored_framer_adler32_unit.sv]
// ============================================================================
// zlib_stored_framer_adler32_unit
// Wraps RGBA pixel bytes into a zlib stream of stored deflate blocks.
// ============================================================================
//
// Usage
//   s_ channel: one RGBA pixel byte per transfer, top-down row order.
//   m_ channel: one zlib stream byte per transfer; m_tlast marks the final
//   Adler-32 byte. cfg_ channel: image_width (index 0), image_height (index 1);
//   cfg_ready is low from first pixel to trailer and while s_tvalid is high.
//   Per image: 0x78 0x01, then per row a zero filter byte and 4*width pixel
//   bytes, split into stored blocks of up to 65535 bytes (BFINAL, LEN, NLEN),
//   then the big-endian Adler-32 of all raw bytes.
// Byte flow
//   A pixel byte is held in the sequencer, follows any zlib header, block
//   header or row filter byte that it causes, and reaches m_ through the
//   output register; the last pixel byte is followed by the trailer. The
//   single byte-per-cycle output register holds on a low m_tready, and
//   s_tready rises in the cycle the sequencer hands over the last byte of a pixel.
// Reset / stall
//   aresetn is synchronous, active low: both dimensions return to 1, the
//   stream restarts with a fresh header. A stalled m_tready holds the output
//   register and a busy sequencer; s_tready then stays low, but is high in idle.
//
`default_nettype none

module zlib_stored_framer_adler32_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // slave stream, tdata[7:0] = pixel_byte
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,
    // master stream, tdata[7:0] = stream_byte, tlast = stream_end
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [7:0]                          m_tdata,
    output logic                                m_tlast,
    // configuration write: index 0 image_width, 1 image_height
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [zsfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [zsfa_pkg::DIM_W-1:0]     cfg_data
);
    import zsfa_pkg::*;

    emit_t       emit;
    adler_ctl_t  adl_ctl;
    adler_sums_t sums;
    logic        slot_free;

    // framing state machine and counters
    zsfa_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .slot_free_i (slot_free),
        .sums_i      (sums),
        .emit_o      (emit),
        .adl_ctl_o   (adl_ctl)
    );

    // checksum over filter and pixel bytes
    zsfa_adler u_adler (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl_i   (adl_ctl),
        .sums_o  (sums)
    );

    // output register decouples the downstream stall
    zsfa_out_reg u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .emit_i      (emit),
        .slot_free_o (slot_free),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top - zlib stored framer bench
// Streams RGBA pixel bytes into the framer under random idling on both sides
// and checks every zlib stream byte and its end marker against typed bytes or
// a local model of the stored-block framing and the running Adler-32. A short
// directed table comes first, then random small images.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import zsfa_pkg::*;

    localparam int CYCLE_LIMIT   = 400_000;
    localparam int TAIL_CYCLES   = 16;        // settle time after last byte
    localparam int RANDOM_PIXELS = 350;

    localparam logic [7:0] BLK_FINAL = 8'h01; // BFINAL set, BTYPE stored
    localparam logic [7:0] BLK_MORE  = 8'h00; // BFINAL clear, BTYPE stored

    // one zlib stream byte as seen on the master side
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } zbeat_t;

    typedef enum logic {STEP_PIXEL, STEP_DIMS} step_kind_e;
    typedef enum logic [1:0] {GAPS_OFF, GAPS_LIGHT, GAPS_FULL} gap_mode_e;

    // directed step: a pixel transfer or a width/height write between images;
    // where n_typed is non-zero the stream bytes are written out by hand,
    // first byte leftmost, and typed_end puts the end marker on the last of them
    typedef struct packed {
        step_kind_e       kind;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [7:0]       px;
        logic [4:0]       n_typed;
        logic [143:0]     typed;
        logic             typed_end;
    } step_t;

    localparam step_t DIRECTED [0:16] = '{
        // after reset the image is 1x1: header, one block of 5, zero pixel
        '{STEP_PIXEL, 15'd0, 15'd0, 8'h00, 5'd9, 144'h78_01_01_05_00_FA_FF_00_00, 1'b0},
        '{STEP_PIXEL, 15'd0, 15'd0, 8'h00, 5'd1, 144'h00, 1'b0},
        '{STEP_PIXEL, 15'd0, 15'd0, 8'h00, 5'd1, 144'h00, 1'b0},
        // all-zero data: Adler high 5, low 1
        '{STEP_PIXEL, 15'd0, 15'd0, 8'h00, 5'd5, 144'h00_00_05_00_01, 1'b1},
        // same size again, all ones
        '{STEP_PIXEL, 15'd0, 15'd0, 8'hFF, 5'd9, 144'h78_01_01_05_00_FA_FF_00_FF, 1'b0},
        '{STEP_PIXEL, 15'd0, 15'd0, 8'hFF, 5'd1, 144'hFF, 1'b0},
        '{STEP_PIXEL, 15'd0, 15'd0, 8'hFF, 5'd1, 144'hFF, 1'b0},
        '{STEP_PIXEL, 15'd0, 15'd0, 8'hFF, 5'd5, 144'hFF_09_FB_03_FD, 1'b1},
        // zero width reads as one; two rows, so a filter byte mid-block
        '{STEP_DIMS,  15'd0, 15'd2, 8'h00, 5'd0, 144'h0, 1'b0},
        '{STEP_PIXEL, 15'd0, 15'd0, 8'h80, 5'd0, 144'h0, 1'b0},
        '{STEP_PIXEL, 15'd0, 15'd0, 8'h7F, 5'd0, 144'h0, 1'b0},
        '{STEP_PIXEL, 15'd0, 15'd0, 8'h01, 5'd0, 144'h0, 1'b0},
        '{STEP_PIXEL, 15'd0, 15'd0, 8'hFE, 5'd0, 144'h0, 1'b0},
        '{STEP_PIXEL, 15'd0, 15'd0, 8'h55, 5'd0, 144'h0, 1'b0},
        '{STEP_PIXEL, 15'd0, 15'd0, 8'hAA, 5'd0, 144'h0, 1'b0},
        '{STEP_PIXEL, 15'd0, 15'd0, 8'hC3, 5'd0, 144'h0, 1'b0},
        '{STEP_PIXEL, 15'd0, 15'd0, 8'h3C, 5'd0, 144'h0, 1'b0}
    };

    // ---- DUT hookup -------------------------------------------------------
    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata   = 8'h00;  // [7:0] pixel_byte
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [7:0]         m_tdata;            // [7:0] stream_byte
    logic               m_tlast;            // stream_end
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
    logic [DIM_W-1:0]   cfg_data  = '0;

    zlib_stored_framer_adler32_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ---- framer model state -----------------------------------------------
    logic [DIM_W-1:0] img_w_reg = 15'd1;   // bits as written
    logic [DIM_W-1:0] img_h_reg = 15'd1;
    logic [15:0]      sum_lo    = 16'd1;   // Adler-32 A
    logic [15:0]      sum_hi    = 16'd0;   // Adler-32 B
    logic [30:0]      raw_left  = '0;      // raw bytes still to frame
    logic [15:0]      blk_left  = '0;      // bytes left in current stored block
    logic [16:0]      row_pos   = '0;      // byte position inside a row
    logic             in_stream = 1'b0;

    zbeat_t    fresh_beats [$];            // bytes caused by the latest pixel
    zbeat_t    stream_expect [$];          // bytes still owed by the framer
    gap_mode_e gap_mode = GAPS_FULL;

    int fails        = 0;
    int pixels_sent  = 0;
    int beats_seen   = 0;
    int images_begun = 0;
    int cycle_count  = 0;
    int stall_left   = 0;

    // zero reads as one, anything past the maximum is clamped
    function automatic logic [DIM_W-1:0] dim_of(input logic [DIM_W-1:0] v);
        if (v == '0) return 15'd1;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        case (gap_mode)
            GAPS_OFF:   return 0;
            GAPS_LIGHT: return (r < 6) ? $urandom_range(1, 2) : 0;
            default: begin
                if (r < 70) return 0;
                if (r < 95) return $urandom_range(1, 3);
                return $urandom_range(10, 40);
            end
        endcase
    endfunction

    // one raw byte into the deflate data, opening a stored block if needed
    function automatic void frame_raw(input logic [7:0] b);
        logic [15:0] len;
        logic [16:0] acc;
        if (blk_left == '0) begin
            len = (raw_left > 31'(BLOCK_MAX)) ? BLOCK_MAX : raw_left[15:0];
            fresh_beats.push_back('{(raw_left <= 31'(BLOCK_MAX)) ? BLK_FINAL : BLK_MORE,
                                    1'b0});
            fresh_beats.push_back('{len[7:0], 1'b0});
            fresh_beats.push_back('{len[15:8], 1'b0});
            fresh_beats.push_back('{~len[7:0], 1'b0});
            fresh_beats.push_back('{~len[15:8], 1'b0});
            blk_left = len;
        end
        fresh_beats.push_back('{b, 1'b0});
        acc = {1'b0, sum_lo} + {9'd0, b};
        if (acc >= {1'b0, ADLER_MOD}) acc = acc - {1'b0, ADLER_MOD};
        sum_lo = acc[15:0];
        acc = {1'b0, sum_hi} + {1'b0, sum_lo};
        if (acc >= {1'b0, ADLER_MOD}) acc = acc - {1'b0, ADLER_MOD};
        sum_hi = acc[15:0];
        blk_left = blk_left - 16'd1;
        raw_left = raw_left - 31'd1;
    endfunction

    // stream bytes caused by one accepted pixel byte
    function automatic void frame_pixel(input logic [7:0] px);
        logic [16:0] row_len;
        row_len = 17'(4 * int'(dim_of(img_w_reg)));
        fresh_beats.delete();
        if (!in_stream) begin
            raw_left  = 31'((int'(row_len) + 1) * int'(dim_of(img_h_reg)));
            sum_lo    = 16'd1;
            sum_hi    = 16'd0;
            blk_left  = '0;
            row_pos   = '0;
            in_stream = 1'b1;
            fresh_beats.push_back('{ZLIB_CMF, 1'b0});
            fresh_beats.push_back('{ZLIB_FLG, 1'b0});
        end
        if (row_pos == '0) frame_raw(FILTER_NONE);
        frame_raw(px);
        row_pos = row_pos + 17'd1;
        if (row_pos >= row_len) row_pos = '0;
        if (raw_left == '0) begin
            // trailer: Adler-32 big-endian, B then A
            fresh_beats.push_back('{sum_hi[15:8], 1'b0});
            fresh_beats.push_back('{sum_hi[7:0], 1'b0});
            fresh_beats.push_back('{sum_lo[15:8], 1'b0});
            fresh_beats.push_back('{sum_lo[7:0], 1'b1});
            sum_lo    = 16'd1;
            sum_hi    = 16'd0;
            blk_left  = '0;
            row_pos   = '0;
            in_stream = 1'b0;
        end
    endfunction

    // Drive one pixel transfer and queue what it should cause. Entered either
    // with s_tvalid low or in the step of the previous transfer, so tvalid is
    // only lowered when a gap is wanted.
    task automatic feed_pixel(input logic [7:0] px, input logic [4:0] n_typed,
                              input logic [143:0] typed, input logic typed_end);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        if (!in_stream) images_begun++;
        pixels_sent++;
        frame_pixel(px);
        if (n_typed == '0) begin
            foreach (fresh_beats[k]) stream_expect.push_back(fresh_beats[k]);
        end else begin
            for (int k = 0; k < int'(n_typed); k++)
                stream_expect.push_back('{typed[(int'(n_typed) - 1 - k) * 8 +: 8],
                                          typed_end && (k == int'(n_typed) - 1)});
        end
    endtask

    // stop feeding, let every owed byte come out, then set the next size;
    // both registers are written back to back, valid held high across them
    task automatic set_image_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        s_tvalid <= 1'b0;
        while (stream_expect.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= w;
        do @(posedge aclk); while (!cfg_ready);
        if (!in_stream) img_w_reg = w;
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= h;
        do @(posedge aclk); while (!cfg_ready);
        if (!in_stream) img_h_reg = h;
        cfg_valid <= 1'b0;
    endtask

    task automatic run_image(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        int n;
        set_image_size(w, h);
        n = 4 * int'(dim_of(w)) * int'(dim_of(h));
        repeat (n) feed_pixel(8'($urandom_range(0, 255)), 5'd0, 144'h0, 1'b0);
    endtask

    // ---- clock, reset, watchdog --------------------------------------------
    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d stream bytes outstanding",
                     cycle_count, stream_expect.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---- master side: random back-pressure ---------------------------------
    always @(posedge aclk) begin
        if (stall_left == 0) stall_left = pick_gap();
        else stall_left--;
        m_tready <= (stall_left == 0);
    end

    // ---- master side: check each transfer against the oldest owed byte -----
    always @(posedge aclk) begin
        zbeat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            beats_seen++;
            if (stream_expect.size() == 0) begin
                $error("unexpected stream byte %02h (tlast %0b)", m_tdata, m_tlast);
                fails++;
            end else begin
                want = stream_expect.pop_front();
                if (m_tdata !== want.data) begin
                    $error("stream_byte: expected %02h, got %02h", want.data, m_tdata);
                    fails++;
                end
                if (m_tlast !== want.last) begin
                    $error("stream_end: expected %0b, got %0b", want.last, m_tlast);
                    fails++;
                end
            end
        end
    end

    // ---- stimulus ------------------------------------------------------------
    initial begin
        step_t st;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        int r;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table: reset size, data extremes, zero width, row filter
        for (int i = 0; i < $size(DIRECTED); i++) begin
            st = DIRECTED[i];
            if (st.kind == STEP_DIMS) set_image_size(st.w, st.h);
            else feed_pixel(st.px, st.n_typed, st.typed, st.typed_end);
        end

        // random small images; zero and odd sizes now and then
        while (pixels_sent < RANDOM_PIXELS + $size(DIRECTED)) begin
            r = $urandom_range(0, 7);
            gap_mode = (r == 0) ? GAPS_OFF : (r == 1) ? GAPS_LIGHT : GAPS_FULL;
            w = ($urandom_range(0, 9) == 0) ? 15'd0 : 15'($urandom_range(1, 6));
            h = ($urandom_range(0, 9) == 0) ? 15'd0 : 15'($urandom_range(1, 5));
            run_image(w, h);
        end

        s_tvalid <= 1'b0;
        while (stream_expect.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d images up to 6x5 pixels, zero sizes read as one, idling on both sides",
                 images_begun);
        $display("%0d pixel bytes sent, %0d stream bytes checked",
                 pixels_sent, beats_seen);
        if (fails == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

[zlib_stored_framer_adler32_unit.f]
+incdir+sv
sv/zsfa_pkg.sv
sv/zsfa_adler.sv
sv/zsfa_out_reg.sv
sv/zsfa_seq.sv
sv/zlib_stored_framer_adler32_unit.sv
bench/tb_top.sv
